### rtl/core/bdch_pkg.sv
// ----------------------------------------------------------------------------
// bdch_pkg
// Shared types and constants for the button debounce, click and hold unit.
// ----------------------------------------------------------------------------
package bdch_pkg;

  localparam int RUN_W      = 8;
  localparam int PRESS_MS_W = 17;
  localparam int HOLD_W     = 16;
  localparam int STABLE_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int BEAT_W     = 8;

  localparam logic [HOLD_W-1:0]   HOLD_TIMEOUT_RESET   = 16'd500;
  localparam logic [STABLE_W-1:0] STABLE_SAMPLES_RESET = 8'd50;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIMEOUT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_SAMPLES = 1'b1;

  // Events raised by the function button press tracker for one beat
  typedef struct packed {
    logic click;
    logic hold;
  } bdch_event_t;

endpackage

### rtl/core/bdch_debounce.sv
// ----------------------------------------------------------------------------
// bdch_debounce
// One-pin debouncer: stable level follows the raw level after a run of
// stable_samples+1 identical samples.
// ----------------------------------------------------------------------------
module bdch_debounce (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          pin,
  input  logic [bdch_pkg::STABLE_W-1:0] stable_samples,
  output logic                          stable,
  output logic                          stable_next
);

  logic                       last_raw;
  logic                       last_raw_next;
  logic [bdch_pkg::RUN_W-1:0] run;
  logic [bdch_pkg::RUN_W-1:0] run_next;
  logic                       pressed;

  // Pin is active low
  assign pressed = ~pin;

  always_comb begin
    last_raw_next = last_raw;
    run_next      = run;
    if (pressed != last_raw) begin
      last_raw_next = pressed;
      run_next      = '0;
    end else if (run != '1) begin
      run_next = run + 1'b1;
    end
    stable_next = (run_next >= stable_samples) ? last_raw_next : stable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= 1'b0;
      run      <= '0;
      stable   <= 1'b0;
    end else if (advance) begin
      last_raw <= last_raw_next;
      run      <= run_next;
      stable   <= stable_next;
    end
  end

endmodule

### rtl/core/bdch_press.sv
// ----------------------------------------------------------------------------
// bdch_press
// Press timer for the function button: raises hold once past the timeout,
// click on a release that raised no hold.
// ----------------------------------------------------------------------------
module bdch_press (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        prev_down,
  input  logic                        cur_down,
  input  logic                        ms_tick,
  input  logic [bdch_pkg::HOLD_W-1:0] hold_timeout_ms,
  output bdch_pkg::bdch_event_t       evt
);

  logic [bdch_pkg::PRESS_MS_W-1:0] press_ms;
  logic [bdch_pkg::PRESS_MS_W-1:0] press_ms_next;
  logic                            hold_done;
  logic                            hold_done_next;

  always_comb begin
    press_ms_next  = press_ms;
    hold_done_next = hold_done;
    evt            = '0;
    if (cur_down) begin
      if (!prev_down) begin
        press_ms_next = '0;
      end else if (ms_tick && (press_ms != '1)) begin
        press_ms_next = press_ms + 1'b1;
      end
      if (!hold_done &&
          (press_ms_next > {{(bdch_pkg::PRESS_MS_W-bdch_pkg::HOLD_W){1'b0}}, hold_timeout_ms}))
      begin
        evt.hold       = 1'b1;
        hold_done_next = 1'b1;
      end
    end else begin
      evt.click      = prev_down && !hold_done;
      press_ms_next  = '0;
      hold_done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ms  <= '0;
      hold_done <= 1'b0;
    end else if (advance) begin
      press_ms  <= press_ms_next;
      hold_done <= hold_done_next;
    end
  end

endmodule

### rtl/core/button_debounce_click_hold_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_click_hold_unit
// Two-button debouncer with click and long-press detection.
// ----------------------------------------------------------------------------
// Each input beat is one sample of two active-low pins (function, push-to-
// talk) plus a millisecond tick. Every accepted beat yields exactly one
// output beat carrying both debounced levels and one-beat click and hold
// pulses for the function button. The unit takes one beat per clock while
// it is not stalled: all work is one short pass of counters and compares
// from the state registers to a single output register, so throughput is
// one beat per cycle and valid rises in the cycle after accept. s_tready stays
// high while the output register is empty or being drained. Configuration
// (hold_timeout_ms at index 0, stable_samples at index 1) is written through
// cfg_we/cfg_index/cfg_data and must only change while the unit is idle.
// ----------------------------------------------------------------------------
module button_debounce_click_hold_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bdch_pkg::BEAT_W-1:0]       s_tdata,   // [0] func_pin, [1] talk_pin, [2] ms_tick
  // Output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bdch_pkg::BEAT_W-1:0]       m_tdata,   // [0] func_down, [1] talk_down,
                                                       // [2] click_pulse, [3] hold_pulse
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [bdch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdch_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [bdch_pkg::HOLD_W-1:0]   hold_timeout_ms;
  logic [bdch_pkg::STABLE_W-1:0] stable_samples;

  logic                  accept;
  logic                  func_stable;
  logic                  func_stable_next;
  logic                  talk_stable;
  logic                  talk_stable_next;
  bdch_pkg::bdch_event_t evt;

  // Accept a new beat whenever the output register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timeout_ms <= bdch_pkg::HOLD_TIMEOUT_RESET;
      stable_samples  <= bdch_pkg::STABLE_SAMPLES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdch_pkg::REG_HOLD_TIMEOUT:   hold_timeout_ms <= cfg_data;
        bdch_pkg::REG_STABLE_SAMPLES: stable_samples  <= cfg_data[bdch_pkg::STABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Debounce both pins
  bdch_debounce u_func_db (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .pin            (s_tdata[0]),
    .stable_samples (stable_samples),
    .stable         (func_stable),
    .stable_next    (func_stable_next)
  );

  bdch_debounce u_talk_db (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .pin            (s_tdata[1]),
    .stable_samples (stable_samples),
    .stable         (talk_stable),
    .stable_next    (talk_stable_next)
  );

  // Press timing on the debounced function level; talk_stable is the held
  // level only, its next value is what the beat reports
  bdch_press u_press (
    .clk             (clk),
    .rst             (rst),
    .advance         (accept),
    .prev_down       (func_stable),
    .cur_down        (func_stable_next),
    .ms_tick         (s_tdata[2]),
    .hold_timeout_ms (hold_timeout_ms),
    .evt             (evt)
  );

  // Output register: load on accept, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'b0000, evt.hold, evt.click, talk_stable_next, func_stable_next};
    end
  end

endmodule

### rtl/core/bdch_checker.sv
// ----------------------------------------------------------------------------
// bdch_checker
// Port-level checks for the button debounce, click and hold unit.
// ----------------------------------------------------------------------------
module bdch_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bdch_pkg::BEAT_W-1:0]     m_tdata
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // Every accepted input beat produces an output beat next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted beat produced no result");

  // Click only on a release, hold only while pressed
  a_click_released: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> !m_tdata[0] && !m_tdata[3])
    else $error("click pulse while function button down");

  a_hold_pressed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[0])
    else $error("hold pulse while function button up");

  // A hold pulse cannot repeat on the next beat of the same press
  a_hold_once: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[3] ##1 m_tvalid |-> !m_tdata[3])
    else $error("hold pulse repeated");

endmodule

bind button_debounce_click_hold_unit bdch_checker u_bdch_checker (.*);

### tb/sv/button_debounce_click_hold_unit_test.sv
// ----------------------------------------------------------------------------
// button_debounce_click_hold_unit_test
// Self-checking bench for the two-button debouncer with click and hold.
// ----------------------------------------------------------------------------
// Sample beats go in through the input stream, and a predictor class tracks
// debounce runs, press time and the hold flag. It queues the beat that each
// accepted sample should produce. Every output beat is checked field by field
// against the oldest queued beat.
// The run has these parts: a phase at reset settings, a short directed part
// (zero debounce, zero timeout, glitches, clicks, holds), random press and
// release sequences under several register settings, and one long press
// that crosses a moderate timeout before release.
// ----------------------------------------------------------------------------
module button_debounce_click_hold_unit_test;

  localparam string PASS_MSG = "button_debounce_click_hold_unit verification clean";
  localparam string FAIL_MSG = "button_debounce_click_hold_unit verification failed";

  // Output beat fields, lowest bit first from the bottom of the struct
  typedef struct packed {
    logic hold_pulse;
    logic click_pulse;
    logic talk_down;
    logic func_down;
  } button_beat_t;

  // --------------------------------------------------------------------------
  // Predictor and store of expected output beats
  // --------------------------------------------------------------------------
  class button_event_predictor;
    logic [bdch_pkg::HOLD_W-1:0]     hold_timeout;
    logic [bdch_pkg::STABLE_W-1:0]   stable_need;
    logic                            func_last;
    logic [bdch_pkg::RUN_W-1:0]      func_run;
    logic                            func_stable;
    logic                            talk_last;
    logic [bdch_pkg::RUN_W-1:0]      talk_run;
    logic                            talk_stable;
    logic [bdch_pkg::PRESS_MS_W-1:0] press_ms;
    logic                            hold_done;
    button_beat_t                    expected_beats[$];
    int                              errors;
    int                              beats_checked;

    function new();
      hold_timeout  = bdch_pkg::HOLD_TIMEOUT_RESET;
      stable_need   = bdch_pkg::STABLE_SAMPLES_RESET;
      func_last     = 1'b0;
      func_run      = '0;
      func_stable   = 1'b0;
      talk_last     = 1'b0;
      talk_run      = '0;
      talk_stable   = 1'b0;
      press_ms      = '0;
      hold_done     = 1'b0;
      errors        = 0;
      beats_checked = 0;
    endfunction

    function void write_reg(logic [bdch_pkg::CFG_IDX_W-1:0] idx,
                            logic [bdch_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        bdch_pkg::REG_HOLD_TIMEOUT: begin
          hold_timeout = value[bdch_pkg::HOLD_W-1:0];
        end
        bdch_pkg::REG_STABLE_SAMPLES: begin
          stable_need = value[bdch_pkg::STABLE_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Level follows the raw pin once the run of identical samples is long enough
    function void debounce_pin(input logic pressed, inout logic last,
                               inout logic [bdch_pkg::RUN_W-1:0] run, inout logic stable);
      if (pressed != last) begin
        last = pressed;
        run  = '0;
      end else if (run != '1) begin
        run = run + 1'b1;
      end
      if (run >= stable_need) begin
        stable = last;
      end
    endfunction

    function void note_sample(logic func_pin, logic talk_pin, logic ms_tick);
      logic         was_down;
      button_beat_t beat;
      was_down = func_stable;
      debounce_pin(~func_pin, func_last, func_run, func_stable);
      debounce_pin(~talk_pin, talk_last, talk_run, talk_stable);
      beat = '0;
      if (func_stable) begin
        // The tick on the press sample itself is not counted
        if (!was_down) begin
          press_ms = '0;
        end else if (ms_tick && press_ms != '1) begin
          press_ms = press_ms + 1'b1;
        end
        if (!hold_done && press_ms > hold_timeout) begin
          beat.hold_pulse = 1'b1;
          hold_done       = 1'b1;
        end
      end else begin
        if (was_down && !hold_done) begin
          beat.click_pulse = 1'b1;
        end
        press_ms  = '0;
        hold_done = 1'b0;
      end
      beat.func_down = func_stable;
      beat.talk_down = talk_stable;
      expected_beats.push_back(beat);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at output beat %0d: %s", beats_checked, msg);
    endtask

    task check_beat(logic [bdch_pkg::BEAT_W-1:0] data);
      string        names[4];
      button_beat_t want;
      names = '{"func_down", "talk_down", "click_pulse", "hold_pulse"};
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("beat %h with no sample pending", data));
      end else begin
        want = expected_beats.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (data[i] !== want[i]) begin
            report_mismatch($sformatf("%s got %b want %b", names[i], data[i], want[i]));
          end
        end
      end
      beats_checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, block and shared bench state
  // --------------------------------------------------------------------------
  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [bdch_pkg::BEAT_W-1:0]     s_tdata;    // [0] func_pin, [1] talk_pin, [2] ms_tick
  logic                            m_tvalid;
  logic                            m_tready;
  logic [bdch_pkg::BEAT_W-1:0]     m_tdata;    // [0] func_down, [1] talk_down,
                                               // [2] click_pulse, [3] hold_pulse
  logic                            cfg_we;
  logic [bdch_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bdch_pkg::CFG_DATA_W-1:0] cfg_data;

  button_event_predictor predictor;
  bit                    snd_idle_en;
  bit                    rcv_idle_en;
  logic                  func_goal;
  int                    beats_sent;
  int                    beats_taken;

  button_debounce_click_hold_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake; the slowest correct run is far shorter
  initial begin
    #2_000_000;
    $display(FAIL_MSG);
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks; all start and end at a falling edge
  // --------------------------------------------------------------------------

  // Offer one sample beat after a random gap when enabled, hold it until accepted
  task automatic send_sample(input logic func_pin, input logic talk_pin, input logic ms_tick);
    int gap;
    gap = snd_idle_en ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {{(bdch_pkg::BEAT_W-3){1'b0}}, ms_tick, talk_pin, func_pin};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predictor.note_sample(func_pin, talk_pin, ms_tick);
    beats_sent++;
    @(negedge clk);
  endtask

  // Drop valid, drain every pending beat, then let the pipeline settle
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (predictor.expected_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bdch_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdch_pkg::CFG_DATA_W-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_we    = 1'b1;
    @(posedge clk);
    predictor.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One press-or-release sequence: some bounce, then a stretch at the goal
  // level. Mostly long enough to debounce; sometimes cut short.
  task automatic play_episode(input int extra_max, input int tick_pct);
    int   span;
    logic talk_goal;
    if ($urandom_range(0, 3) != 0) begin
      func_goal = ~func_goal;
    end
    talk_goal   = 1'($urandom_range(0, 1));
    snd_idle_en = ($urandom_range(0, 3) != 0);
    rcv_idle_en = ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(0, 3)) begin
      send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 4) == 0) begin
      span = $urandom_range(1, predictor.stable_need + 1);
    end else begin
      span = predictor.stable_need + 1 + $urandom_range(0, extra_max);
    end
    for (int k = 0; k < span; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        talk_goal = ~talk_goal;
      end
      send_sample(~func_goal, ~talk_goal, $urandom_range(0, 99) < tick_pct);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls, two long hold-offs, check every beat
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = rcv_idle_en ? $urandom_range(0, 7) : 0;
      // Hold off long enough for the block to fill and stall its input
      if (beats_taken == 300 || beats_taken == 900) begin
        stall = 60;
      end
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      predictor.check_beat(m_tdata);
      beats_taken++;
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ss_tab[9];
    int hold_tab[9];
    int phase_start;
    int extra;
    int tick_pct;

    ss_tab   = '{0, 1, 3, 2, 0, 7, 255, 4, 1};
    hold_tab = '{0, 3, 10, 1, 65535, 5, 2, 0, 20};

    predictor   = new();
    beats_sent  = 0;
    beats_taken = 0;
    snd_idle_en = 1'b1;
    rcv_idle_en = 1'b1;
    func_goal   = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Reset settings: 51 identical samples to move a level
    phase_start = beats_sent;
    while (beats_sent - phase_start < 200) begin
      play_episode(20, 60);
    end

    // Directed: zero debounce and zero timeout. Upper data bits of the
    // stable_samples write lie outside the register and must be dropped.
    wait_idle();
    snd_idle_en = 1'b1;
    rcv_idle_en = 1'b1;
    write_reg(bdch_pkg::REG_HOLD_TIMEOUT, 16'd0);
    write_reg(bdch_pkg::REG_STABLE_SAMPLES, 16'hA500);
    send_sample(1'b1, 1'b1, 1'b0);   // all released
    send_sample(1'b0, 1'b1, 1'b1);   // press with tick: tick not counted
    send_sample(1'b0, 1'b1, 1'b0);   // no tick, no hold
    send_sample(1'b0, 1'b1, 1'b1);   // first tick after press: hold
    send_sample(1'b0, 1'b0, 1'b1);   // talk down, no second hold
    send_sample(1'b1, 1'b0, 1'b0);   // release after hold: no click
    send_sample(1'b0, 1'b0, 1'b0);   // press again
    send_sample(1'b1, 1'b1, 1'b1);   // short press released: click

    // Directed: one extra sample of debounce, timeout of two
    wait_idle();
    write_reg(bdch_pkg::REG_STABLE_SAMPLES, 16'd1);
    write_reg(bdch_pkg::REG_HOLD_TIMEOUT, 16'd2);
    send_sample(1'b0, 1'b1, 1'b1);   // single pressed sample: not yet down
    send_sample(1'b1, 1'b1, 1'b0);   // bounce
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1);   // debounced press
    send_sample(1'b0, 1'b1, 1'b1);
    send_sample(1'b0, 1'b1, 1'b1);   // count equals timeout: no hold yet
    send_sample(1'b1, 1'b1, 1'b1);   // glitch keeps level, tick raises hold
    send_sample(1'b0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);   // released after hold: no click
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1);   // both down
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);   // both up, click

    // Random sequences under a spread of settings, extremes included
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      write_reg(bdch_pkg::REG_STABLE_SAMPLES,
                16'(($urandom & 32'hFF00) | ss_tab[p]));
      write_reg(bdch_pkg::REG_HOLD_TIMEOUT, 16'(hold_tab[p]));
      extra       = (hold_tab[p] > 30) ? 40 : 2 * hold_tab[p] + 6;
      tick_pct    = $urandom_range(30, 100);
      phase_start = beats_sent;
      while (beats_sent - phase_start < 80) begin
        play_episode(extra, tick_pct);
      end
    end

    // Long press: tick well past a moderate timeout, then release
    wait_idle();
    write_reg(bdch_pkg::REG_STABLE_SAMPLES, 16'd0);
    write_reg(bdch_pkg::REG_HOLD_TIMEOUT, 16'd20);
    snd_idle_en = 1'b0;
    rcv_idle_en = 1'b0;
    send_sample(1'b1, 1'b1, 1'b0);
    repeat (30) send_sample(1'b0, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0);   // release after hold: no click

    // Drain, then watch a little longer for stray beats
    wait_idle();
    repeat (8) @(negedge clk);
    while (predictor.expected_beats.size() != 0) begin
      void'(predictor.expected_beats.pop_front());
      predictor.report_mismatch("expected beat never arrived");
    end
    if (predictor.errors == 0) begin
      $display(PASS_MSG);
    end else begin
      $display(FAIL_MSG);
    end
    $finish;
  end

endmodule

### files.f
rtl/core/bdch_pkg.sv
rtl/core/bdch_debounce.sv
rtl/core/bdch_press.sv
rtl/core/button_debounce_click_hold_unit.sv
rtl/core/bdch_checker.sv
tb/sv/button_debounce_click_hold_unit_test.sv
